@@ rtl/core/triangle_min_path_sum_top_assert.svh @@
// Assertion macros for the triangle minimum path sum block.
// The asserting module must provide clk_i and rst_ni.
`ifndef TRIANGLE_MIN_PATH_SUM_TOP_ASSERT_SVH
`define TRIANGLE_MIN_PATH_SUM_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define TMPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check that a stalled word keeps its valid and its payload.
`define TMPS_HOLD(lbl, vld, rdy, data, msg) \
  `TMPS_ASSERT(lbl, (vld) && !(rdy) |=> (vld) && $stable(data), msg)

`endif

@@ rtl/core/tmps_pkg.sv @@
package tmps_pkg;

  localparam int SUM_W          = 22;
  localparam int NR_W           = 7;
  localparam int APB_DW         = 32;
  localparam int APB_AW         = 3;
  localparam int DEF_MAX_ROWS   = 64;
  localparam int DEF_VALUE_BITS = 16;

  localparam logic signed [SUM_W-1:0] SUM_MAX = 22'sh1FFFFF;
  localparam logic signed [SUM_W-1:0] SUM_MIN = -22'sh200000;

  localparam logic [NR_W-1:0]   NUM_ROWS_RESET = 7'd1;
  localparam logic [APB_AW-1:0] NUM_ROWS_ADDR  = 3'd0;

  typedef struct packed {
    logic row0;
    logic col0;
    logic has_old;
    logic end_row;
    logic last_row;
    logic fwd;
  } item_ctl_t;

endpackage

@@ rtl/core/tmps_ram.sv @@
module tmps_ram #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/tmps_front.sv @@
module tmps_front import tmps_pkg::*; #(
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [VALUE_BITS-1:0] value_i,
  input  logic [NR_W-1:0]              num_rows_i,
  input  logic                         adv_i,
  output logic                         s0_valid_o,
  output logic signed [VALUE_BITS-1:0] value_o,
  output item_ctl_t                    ctl_o,
  output logic [AW-1:0]                col_o,
  output logic                         rd_en_o,
  output logic [AW-1:0]                rd_addr_o
);

  localparam int CLW = $clog2(MAX_ROWS + 1);
  localparam int EW  = (CLW > NR_W) ? CLW + 1 : NR_W + 1;

  logic [AW-1:0]                row_q, row_d;
  logic [AW-1:0]                col_q, col_d;
  logic                         s0_valid_q, s0_valid_d;
  logic signed [VALUE_BITS-1:0] value_q;
  item_ctl_t                    ctl_q, ctl_d;
  logic [AW-1:0]                s0_col_q;
  logic [EW-1:0]                nr_ext, nr_eff;
  logic                         accept;

  always_comb begin
    nr_ext = EW'(num_rows_i);
    if (nr_ext == '0) begin
      nr_eff = EW'(1);
    end else if (nr_ext > EW'(MAX_ROWS)) begin
      nr_eff = EW'(MAX_ROWS);
    end else begin
      nr_eff = nr_ext;
    end
  end

  assign in_ready_o = !s0_valid_q || adv_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    ctl_d.row0     = (row_q == '0);
    ctl_d.col0     = (col_q == '0);
    ctl_d.has_old  = (col_q < row_q);
    ctl_d.end_row  = (col_q >= row_q);
    ctl_d.last_row = ((EW'(row_q) + EW'(1)) >= nr_eff);
    ctl_d.fwd      = s0_valid_q && adv_i && (s0_col_q == col_q);

    row_d = row_q;
    col_d = col_q;
    if (accept) begin
      if (ctl_d.end_row) begin
        col_d = '0;
        row_d = ctl_d.last_row ? '0 : row_q + AW'(1);
      end else begin
        col_d = col_q + AW'(1);
      end
    end

    s0_valid_d = s0_valid_q;
    if (accept) begin
      s0_valid_d = 1'b1;
    end else if (adv_i) begin
      s0_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= '0;
      col_q      <= '0;
      s0_valid_q <= 1'b0;
      ctl_q      <= '0;
    end else begin
      row_q      <= row_d;
      col_q      <= col_d;
      s0_valid_q <= s0_valid_d;
      if (accept) begin
        ctl_q <= ctl_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      value_q  <= value_i;
      s0_col_q <= col_q;
    end
  end

  assign s0_valid_o = s0_valid_q;
  assign value_o    = value_q;
  assign ctl_o      = ctl_q;
  assign col_o      = s0_col_q;
  assign rd_en_o    = accept;
  assign rd_addr_o  = col_q;

endmodule

@@ rtl/core/tmps_update.sv @@
module tmps_update import tmps_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS,
  parameter int AW         = 6
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s0_valid_i,
  input  logic signed [VALUE_BITS-1:0] value_i,
  input  item_ctl_t                    ctl_i,
  input  logic [AW-1:0]                col_i,
  input  logic [SUM_W-1:0]             rd_data_i,
  output logic                         adv_o,
  output logic                         wr_en_o,
  output logic [AW-1:0]                wr_addr_o,
  output logic [SUM_W-1:0]             wr_data_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [SUM_W-1:0]      min_sum_o
);

  localparam int SW = ((VALUE_BITS > SUM_W) ? VALUE_BITS : SUM_W) + 1;
  localparam logic signed [SW-1:0] SMAX = SW'(SUM_MAX);
  localparam logic signed [SW-1:0] SMIN = SW'(SUM_MIN);

  logic signed [SUM_W-1:0] held_q, held_d;
  logic signed [SUM_W-1:0] bottom_q, bottom_d;
  logic signed [SUM_W-1:0] fwd_data_q;
  logic                    out_valid_q, out_valid_d;
  logic signed [SUM_W-1:0] min_sum_q, min_sum_d;

  logic signed [SUM_W-1:0] old, parent, fresh, best;
  logic signed [SW-1:0]    sum;
  logic                    res;

  always_comb begin
    old = '0;
    if (ctl_i.has_old) begin
      old = ctl_i.fwd ? fwd_data_q : $signed(rd_data_i);
    end

    if (ctl_i.row0) begin
      parent = '0;
    end else if (ctl_i.col0) begin
      parent = old;
    end else if (ctl_i.end_row) begin
      parent = held_q;
    end else begin
      parent = (held_q < old) ? held_q : old;
    end

    sum = SW'(value_i) + SW'(parent);
    if (sum > SMAX) begin
      fresh = SUM_MAX;
    end else if (sum < SMIN) begin
      fresh = SUM_MIN;
    end else begin
      fresh = sum[SUM_W-1:0];
    end

    best  = (ctl_i.last_row && (fresh < bottom_q)) ? fresh : bottom_q;
    res   = ctl_i.end_row && ctl_i.last_row;
    adv_o = s0_valid_i && (!res || !out_valid_q || out_ready_i);

    held_d   = held_q;
    bottom_d = bottom_q;
    if (adv_o) begin
      held_d   = ctl_i.end_row ? '0 : old;
      bottom_d = res ? SUM_MAX : best;
    end

    out_valid_d = out_valid_q;
    min_sum_d   = min_sum_q;
    if (adv_o && res) begin
      out_valid_d = 1'b1;
      min_sum_d   = best;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      bottom_q    <= SUM_MAX;
      out_valid_q <= 1'b0;
    end else begin
      held_q      <= held_d;
      bottom_q    <= bottom_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    min_sum_q <= min_sum_d;
    if (adv_o) begin
      fwd_data_q <= fresh;
    end
  end

  assign wr_en_o     = adv_o;
  assign wr_addr_o   = col_i;
  assign wr_data_o   = fresh;
  assign out_valid_o = out_valid_q;
  assign min_sum_o   = min_sum_q;

endmodule

@@ rtl/core/triangle_min_path_sum_top.sv @@
// Minimum top-to-bottom path sum of a number triangle.
// Input channel: in_valid_i/in_ready_o carry one triangle entry per word on
// value_i, row-major, top row first; row i holds i+1 entries.
// Output channel: out_valid_o/out_ready_i carry one word on min_sum_o per
// triangle, produced by the triangle's last entry. Other entries give none.
// num_rows sits at APB byte address 0; 0 acts as 1, above MAX_ROWS as
// MAX_ROWS. Write it only while the block is idle.
// Throughput: one entry per cycle while no result stalls. Each entry does one
// row buffer read, one add, one saturation and two compares, then writes the
// buffer back. The last entry passes the input register, then its result
// goes to the result register; it waits in the input register while an
// earlier result is unread. The row buffer read is issued at accept; a write
// one entry back to the same column is forwarded.
// Reset: clears position, running minimum and the output register; num_rows
// returns to 1. The row buffer is not cleared, as every entry is written
// before it is read within a triangle.
// Receiver stall: the result word holds; entries keep flowing until the next
// result would need the output register, then in_ready_o drops.
module triangle_min_path_sum_top import tmps_pkg::*; #(
  parameter int MAX_ROWS   = DEF_MAX_ROWS,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [VALUE_BITS-1:0] value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [SUM_W-1:0]      min_sum_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [APB_AW-1:0]            paddr,
  input  logic [APB_DW-1:0]            pwdata,
  output logic [APB_DW-1:0]            prdata,
  output logic                         pready
);

  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

  logic [NR_W-1:0]              num_rows_q;
  logic                         adv;
  logic                         s0_valid;
  logic signed [VALUE_BITS-1:0] s0_value;
  item_ctl_t                    s0_ctl;
  logic [AW-1:0]                s0_col;
  logic                         rd_en, wr_en;
  logic [AW-1:0]                rd_addr, wr_addr;
  logic [SUM_W-1:0]             rd_data, wr_data;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_rows_q <= NUM_ROWS_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == NUM_ROWS_ADDR)) begin
      num_rows_q <= pwdata[NR_W-1:0];
    end
  end

  assign prdata = (paddr == NUM_ROWS_ADDR) ? APB_DW'(num_rows_q) : '0;

  tmps_front #(
    .MAX_ROWS  (MAX_ROWS),
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .value_i   (value_i),
    .num_rows_i(num_rows_q),
    .adv_i     (adv),
    .s0_valid_o(s0_valid),
    .value_o   (s0_value),
    .ctl_o     (s0_ctl),
    .col_o     (s0_col),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr)
  );

  tmps_ram #(
    .WIDTH(SUM_W),
    .DEPTH(MAX_ROWS)
  ) u_row_best (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (rd_en),
    .raddr_i(rd_addr),
    .rdata_o(rd_data)
  );

  tmps_update #(
    .VALUE_BITS(VALUE_BITS),
    .AW        (AW)
  ) u_update (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s0_valid_i (s0_valid),
    .value_i    (s0_value),
    .ctl_i      (s0_ctl),
    .col_i      (s0_col),
    .rd_data_i  (rd_data),
    .adv_o      (adv),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .min_sum_o  (min_sum_o)
  );

endmodule

@@ rtl/core/tmps_checker.sv @@
`include "triangle_min_path_sum_top_assert.svh"

module tmps_checker import tmps_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic [VALUE_BITS-1:0] value_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [SUM_W-1:0]      min_sum_o,
  input logic                  psel,
  input logic                  penable,
  input logic                  pwrite,
  input logic [APB_AW-1:0]     paddr,
  input logic [APB_DW-1:0]     pwdata,
  input logic [APB_DW-1:0]     prdata,
  input logic                  pready
);

  `TMPS_HOLD(a_in_hold, in_valid_i, in_ready_o, value_i, "input word changed while stalled")

  `TMPS_HOLD(a_out_hold, out_valid_o, out_ready_i, min_sum_o, "result word changed while stalled")

  `TMPS_ASSERT(a_pready_high, pready, "pready dropped")

  `TMPS_ASSERT(a_stall_cause, !in_ready_o |-> out_valid_o && !out_ready_i, "input stalled without a waiting result")

  `TMPS_ASSERT(a_cfg_readback, psel && penable && pwrite && (paddr == NUM_ROWS_ADDR) |=> (paddr != NUM_ROWS_ADDR) || (prdata[NR_W-1:0] == $past(pwdata[NR_W-1:0])), "num_rows readback mismatch")

endmodule

bind triangle_min_path_sum_top tmps_checker #(
  .VALUE_BITS(VALUE_BITS)
) u_tmps_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .value_i    (value_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .min_sum_o  (min_sum_o),
  .psel       (psel),
  .penable    (penable),
  .pwrite     (pwrite),
  .paddr      (paddr),
  .pwdata     (pwdata),
  .prdata     (prdata),
  .pready     (pready)
);
